// File: design/iirdf2_pkg.sv
// ----------------------------------------------------------------------------
// IIR direct form II package
// Shared widths, register indexes, sequencer steps and rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf2_pkg;

  localparam int ORDER     = 3;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int AUX_W     = 24;
  localparam int FRAC_W    = 14;
  localparam int PROD_W    = COEF_W + AUX_W;
  localparam int ACC_W     = 45;
  localparam int RND_W     = ACC_W - FRAC_W;
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd6;

  localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_W - 1);

  // Sequencer steps: each but STEP_LAST names the product it issues
  localparam logic [STEP_W-1:0] STEP_A1H1 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_A2H2 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_A3H3 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_B1H1 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_B2H2 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_B3H3 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_B0W  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic load_x;
    logic load_prod;
    logic add;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [AUX_W-1:0] value;
    logic                    ovf;
  } aux_sat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       ovf;
  } out_sat_t;

  // Add half an LSB, then floor shift by the fraction width
  function automatic logic [RND_W-1:0] round_acc(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] biased;
    biased = acc + ROUND_BIAS;
    return biased[ACC_W-1:FRAC_W];
  endfunction

  function automatic aux_sat_t sat_aux(input logic [RND_W-1:0] v);
    aux_sat_t res;
    logic [RND_W-AUX_W:0] top;
    top = v[RND_W-1:AUX_W-1];
    res.ovf = (top != '0) && (top != '1);
    if (res.ovf) begin
      res.value = v[RND_W-1] ? {1'b1, {(AUX_W-1){1'b0}}} : {1'b0, {(AUX_W-1){1'b1}}};
    end else begin
      res.value = v[AUX_W-1:0];
    end
    return res;
  endfunction

  function automatic out_sat_t sat_out(input logic [RND_W-1:0] v);
    out_sat_t res;
    logic [RND_W-SAMPLE_W:0] top;
    top = v[RND_W-1:SAMPLE_W-1];
    res.ovf = (top != '0) && (top != '1);
    if (res.ovf) begin
      res.value = v[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      res.value = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/iirdf2_mac.sv
// ----------------------------------------------------------------------------
// IIR direct form II multiply-accumulate unit
// Registered 18x24 signed multiplier feeding a 45-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf2_mac import iirdf2_pkg::*; (
  input  wire logic                       clk,
  input  wire mac_ctrl_t                  ctrl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic signed [COEF_W-1:0]   coef,
  input  wire logic signed [AUX_W-1:0]    data,
  output      logic [ACC_W-1:0]           acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         sample_ext;

  assign prod_ext   = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign sample_ext = {{(ACC_W-SAMPLE_W-FRAC_W){sample[SAMPLE_W-1]}}, sample,
                       {FRAC_W{1'b0}}};

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load_x) begin
      acc_nxt = sample_ext;
    end else if (ctrl.load_prod) begin
      acc_nxt = prod_ext;
    end else if (ctrl.add) begin
      acc_nxt = acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * data;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: design/iir_direct_form_two_filter.sv
// ----------------------------------------------------------------------------
// Third-order direct form II IIR filter
// One shared MAC computes the auxiliary value and the output per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed 16-bit sample per request (valid/ready).
//   out_* : one saturated 16-bit response plus overflow flag per request.
//   cfg_* : write channel for the seven Q3.14 gains, index 0..6, always
//           ready; an index of 7 is dropped. Write only while idle.
// Timing:
//   A sample runs from acceptance to out_valid through eight steps of
//   the registered multiplier and accumulator (seven products, each
//   accumulated in the step after its issue) and one step to round and
//   saturate the output. in_ready is high only when the sequencer is
//   idle, so a new sample is taken only once the last one is done.
//   The result sits in an output register; if the receiver stalls, the
//   sequencer holds in its final step until the register frees up.
// Reset:
//   rst_n (synchronous) clears the history, loads gain b0 = 1.0 and the
//   other gains to zero, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_two_filter import iirdf2_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample_in,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic signed [SAMPLE_W-1:0]  out_sample_out,
  output      logic                        out_overflow,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic signed [COEF_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic signed [COEF_W-1:0]   gain_r [NUM_REGS];
  logic signed [AUX_W-1:0]    hist_r [ORDER];
  logic signed [AUX_W-1:0]    w_r;
  logic                       ovf_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_out_r;
  logic                       overflow_r;

  mac_ctrl_t                  mac_ctrl;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [AUX_W-1:0]    data_sel;
  logic [ACC_W-1:0]           acc;
  aux_sat_t                   w_sat;
  out_sat_t                   y_sat;
  logic                       in_fire;
  logic                       out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign w_sat = sat_aux(round_acc(acc));
  assign y_sat = sat_out(round_acc(acc));

  // Operand select for the product issued this step
  always_comb begin
    case (step_r)
      STEP_A1H1: begin coef_sel = gain_r[REG_A1]; data_sel = hist_r[0]; end
      STEP_A2H2: begin coef_sel = gain_r[REG_A2]; data_sel = hist_r[1]; end
      STEP_A3H3: begin coef_sel = gain_r[REG_A3]; data_sel = hist_r[2]; end
      STEP_B1H1: begin coef_sel = gain_r[REG_B1]; data_sel = hist_r[0]; end
      STEP_B2H2: begin coef_sel = gain_r[REG_B2]; data_sel = hist_r[1]; end
      STEP_B3H3: begin coef_sel = gain_r[REG_B3]; data_sel = hist_r[2]; end
      STEP_B0W:  begin coef_sel = gain_r[REG_B0]; data_sel = w_r;       end
      default:   begin coef_sel = gain_r[REG_B0]; data_sel = w_r;       end
    endcase
  end

  // Load x, then sum each product one step after issue; B2H2 starts anew
  always_comb begin
    mac_ctrl = '0;
    if (in_fire) begin
      mac_ctrl.load_x = 1'b1;
    end else if (state_r == ST_RUN) begin
      if (step_r == STEP_B2H2) begin
        mac_ctrl.load_prod = 1'b1;
      end else if (step_r != STEP_A1H1) begin
        mac_ctrl.add = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          step_nxt  = STEP_A1H1;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  iirdf2_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .sample (in_sample_in),
    .coef   (coef_sel),
    .data   (data_sel),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_REGS; k++) begin
        gain_r[k] <= (CFG_IDX_W'(k) == REG_B0) ? B0_RESET : '0;
      end
      for (int k = 0; k < ORDER; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;

      if (cfg_valid && cfg_ready && (cfg_index <= REG_A3)) begin
        gain_r[cfg_index] <= cfg_data;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        // advance the history with the new auxiliary value
        hist_r[0] <= w_r;
        for (int k = 1; k < ORDER; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ovf_r <= 1'b0;
    end else if ((state_r == ST_RUN) && (step_r == STEP_B2H2)) begin
      w_r   <= w_sat.value;
      ovf_r <= w_sat.ovf;
    end
    if (out_load) begin
      sample_out_r <= y_sat.value;
      overflow_r   <= ovf_r || y_sat.ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_out_r;
  assign out_overflow   = overflow_r;

endmodule

`default_nettype wire
